// ----- rtl/ntp_pkg.sv -----
// Shared types, constants and spelling tables for the pseudoword encoder.
package ntp_pkg;

	localparam int NUM_W = 31;
	localparam int CNT_W = $clog2(NUM_W);
	localparam int REM_W = 9;
	localparam logic [REM_W:0] EN_BASE = 10'd330;
	localparam logic [REM_W:0] JP_BASE = 10'd39;
	// reciprocal of 11 scaled by 2^13, exact for values below 330
	localparam logic [9:0] RECIP_11 = 10'd745;
	localparam int RECIP_SH = 13;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic             japanese;
		logic [NUM_W-1:0] dividend;
	} div_ctl_t;

	typedef struct packed {
		logic done;
		logic qzero;
	} div_stat_t;

	// spellings: first letter in the upper byte, zero lower byte for one letter
	function automatic logic [15:0] vowel_sp(input logic [3:0] idx);
		logic [15:0] sp;
		unique case (idx)
			4'd0:    sp = {"a", 8'h00};
			4'd1:    sp = {"y", 8'h00};
			4'd2:    sp = {"u", 8'h00};
			4'd3:    sp = {"o", 8'h00};
			4'd4:    sp = "ar";
			4'd5:    sp = "aw";
			4'd6:    sp = "ee";
			4'd7:    sp = "er";
			4'd8:    sp = "ey";
			4'd9:    sp = "or";
			4'd10:   sp = "oy";
			default: sp = {"a", 8'h00};
		endcase
		return sp;
	endfunction

	function automatic logic [15:0] consonant_sp(input logic [4:0] idx);
		logic [15:0] sp;
		unique case (idx)
			5'd0:    sp = {"b", 8'h00};
			5'd1:    sp = {"d", 8'h00};
			5'd2:    sp = {"f", 8'h00};
			5'd3:    sp = {"g", 8'h00};
			5'd4:    sp = {"j", 8'h00};
			5'd5:    sp = {"k", 8'h00};
			5'd6:    sp = {"l", 8'h00};
			5'd7:    sp = {"m", 8'h00};
			5'd8:    sp = {"n", 8'h00};
			5'd9:    sp = {"p", 8'h00};
			5'd10:   sp = {"r", 8'h00};
			5'd11:   sp = {"s", 8'h00};
			5'd12:   sp = {"t", 8'h00};
			5'd13:   sp = {"v", 8'h00};
			5'd14:   sp = {"w", 8'h00};
			5'd15:   sp = {"z", 8'h00};
			5'd16:   sp = "ch";
			5'd17:   sp = "sh";
			5'd18:   sp = "bl";
			5'd19:   sp = "fl";
			5'd20:   sp = "gl";
			5'd21:   sp = "kl";
			5'd22:   sp = "pl";
			5'd23:   sp = "sk";
			5'd24:   sp = "sl";
			5'd25:   sp = "sm";
			5'd26:   sp = "sn";
			5'd27:   sp = "sp";
			5'd28:   sp = "st";
			5'd29:   sp = "sw";
			default: sp = {"b", 8'h00};
		endcase
		return sp;
	endfunction

	function automatic logic [15:0] syllable_sp(input logic [5:0] idx);
		logic [15:0] sp;
		unique case (idx)
			6'd0:    sp = "wa";
			6'd1:    sp = "ra";
			6'd2:    sp = "ri";
			6'd3:    sp = "ru";
			6'd4:    sp = "re";
			6'd5:    sp = "ro";
			6'd6:    sp = "ya";
			6'd7:    sp = "yu";
			6'd8:    sp = "yo";
			6'd9:    sp = "ma";
			6'd10:   sp = "mi";
			6'd11:   sp = "mu";
			6'd12:   sp = "me";
			6'd13:   sp = "mo";
			6'd14:   sp = "ha";
			6'd15:   sp = "hi";
			6'd16:   sp = "hu";
			6'd17:   sp = "he";
			6'd18:   sp = "ho";
			6'd19:   sp = "na";
			6'd20:   sp = "ni";
			6'd21:   sp = "nu";
			6'd22:   sp = "ne";
			6'd23:   sp = "no";
			6'd24:   sp = "ta";
			6'd25:   sp = "ti";
			6'd26:   sp = "tu";
			6'd27:   sp = "te";
			6'd28:   sp = "to";
			6'd29:   sp = "sa";
			6'd30:   sp = "si";
			6'd31:   sp = "su";
			6'd32:   sp = "se";
			6'd33:   sp = "so";
			6'd34:   sp = "ka";
			6'd35:   sp = "ki";
			6'd36:   sp = "ku";
			6'd37:   sp = "ke";
			6'd38:   sp = "ko";
			default: sp = "wa";
		endcase
		return sp;
	endfunction

endpackage

// ----- rtl/number_to_pseudoword_top.sv -----
// Top level of the pseudoword encoder: digit sequencer and letter output stage.
// For each digit the divider runs its 31 shifts, the spelling of the digit is loaded, and
// then its letters are emitted. A request yields up to 4 English digits or 6 Japanese
// digits; one request is in flight at a time.
// Reset: arst_n clears the sequencer, divider control and output valid.
module number_to_pseudoword_top
	import ntp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [NUM_W-1:0] number,
	input  logic             language,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       character,
	output logic             last_char
);

	state_t state_q, state_nxt;

	div_ctl_t         div_ctl;
	div_stat_t        div_stat;
	logic [NUM_W-1:0] quot;
	logic [REM_W-1:0] rem;

	// request-wide state
	logic             jp_q;
	logic             qzero_q;   // this digit is the most significant one

	// letters of the current digit, emitted from the top byte down
	logic [31:0]      letters_q;
	logic [2:0]       nlet_q;

	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic             emit;      // move one letter into the output register
	logic             load;      // capture the spellings of a finished digit

	// digit split: consonant = d / 11 by reciprocal, vowel = d - 11 * consonant
	logic [18:0]      prod;
	logic [4:0]       cons_idx;
	logic [REM_W-1:0] c11;
	logic [3:0]       vow_idx;
	logic [15:0]      c_sp, v_sp, s_sp;
	logic [31:0]      letters_nxt;
	logic [2:0]       nlet_nxt;

	ntp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.stat      (div_stat),
		.quotient  (quot),
		.remainder (rem)
	);

	always_comb begin
		prod     = 19'(rem) * 19'(RECIP_11);
		cons_idx = prod[RECIP_SH+4:RECIP_SH];
		c11      = REM_W'({cons_idx, 3'b000}) + REM_W'({cons_idx, 1'b0}) + REM_W'(cons_idx);
		vow_idx  = 4'(rem - c11);
		c_sp     = consonant_sp(cons_idx);
		v_sp     = vowel_sp(vow_idx);
		s_sp     = syllable_sp(rem[5:0]);

		if (jp_q) begin
			letters_nxt = {s_sp, 16'h0000};
			nlet_nxt    = 3'd2;
		end else if (c_sp[7:0] == 8'h00) begin
			letters_nxt = {c_sp[15:8], v_sp, 8'h00};
			nlet_nxt    = (v_sp[7:0] == 8'h00) ? 3'd2 : 3'd3;
		end else begin
			letters_nxt = {c_sp, v_sp};
			nlet_nxt    = (v_sp[7:0] == 8'h00) ? 3'd3 : 3'd4;
		end
	end

	// sequencer: divide, then spell the digit, repeat until the quotient is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt        = state_q;
		in_ready         = 1'b0;
		load             = 1'b0;
		emit             = 1'b0;
		div_ctl.start    = 1'b0;
		div_ctl.japanese = jp_q;
		div_ctl.dividend = quot;
		unique case (state_q)
			ST_IDLE: begin
				in_ready         = 1'b1;
				div_ctl.japanese = language;
				div_ctl.dividend = number;
				if (in_valid) begin
					div_ctl.start = 1'b1;
					state_nxt     = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					load      = 1'b1;
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				emit = !out_valid_q || out_ready;
				if (emit && nlet_q == 3'd1) begin
					if (qzero_q) begin
						state_nxt = ST_IDLE;
					end else begin
						div_ctl.start = 1'b1;
						state_nxt     = ST_DIV;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			jp_q <= language;
		end
		if (load) begin
			letters_q <= letters_nxt;
			nlet_q    <= nlet_nxt;
			qzero_q   <= div_stat.qzero;
		end else if (emit) begin
			letters_q <= {letters_q[23:0], 8'h00};
			nlet_q    <= nlet_q - 1'b1;
		end
		if (emit) begin
			char_q <= letters_q[31:24];
			last_q <= (nlet_q == 3'd1) && qzero_q;
		end
	end

	// output register: while a digit is emitted, refilled when empty or in the cycle the held letter is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last_char = last_q;

endmodule

// ----- rtl/ntp_div.sv -----
// Bit-serial restoring divider by 330 or 39, one quotient bit per cycle.
module ntp_div
	import ntp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	output div_stat_t        stat,
	output logic [NUM_W-1:0] quotient,
	output logic [REM_W-1:0] remainder
);

	logic [NUM_W-1:0] num_q;
	logic [REM_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             jp_q;

	logic [REM_W:0]   rem_sh;
	logic [REM_W:0]   base;
	logic             ge;
	logic [REM_W-1:0] rem_nxt;

	always_comb begin
		base    = jp_q ? JP_BASE : EN_BASE;
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		ge      = (rem_sh >= base);
		rem_nxt = ge ? REM_W'(rem_sh - base) : rem_sh[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= ctl.dividend;
			rem_q <= '0;
			jp_q  <= ctl.japanese;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient   = num_q;
	assign remainder  = rem_q;
	assign stat.done  = done_q;
	assign stat.qzero = (num_q == '0);

endmodule
